// File: src/rv64im_integer_execute_unit_defines.svh
// Assertion macros for the rv64im execute unit checker.
// Included by the checker file; no other dependencies.
`ifndef RV64IM_INTEGER_EXECUTE_UNIT_DEFINES_SVH
`define RV64IM_INTEGER_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, off in reset
`define RV64EX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rv64ex assertion failed");

// next-cycle implication
`define RV64EX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rv64ex assertion failed");

`endif

// File: src/rv64ex_pkg.sv
// Shared types, codes and step functions of the rv64im execute unit.
// No dependencies.
package rv64ex_pkg;

  localparam int NCELLS         = 32;
  localparam int STEPS_PER_CELL = 2;

  // operation codes
  localparam logic [5:0] OP_AUIPC = 6'd0;
  localparam logic [5:0] OP_LUI   = 6'd1;
  localparam logic [5:0] OP_ADD   = 6'd2;
  localparam logic [5:0] OP_MUL   = 6'd3;
  localparam logic [5:0] OP_SUB   = 6'd4;
  localparam logic [5:0] OP_OR    = 6'd5;
  localparam logic [5:0] OP_XOR   = 6'd6;
  localparam logic [5:0] OP_AND   = 6'd7;
  localparam logic [5:0] OP_SLT   = 6'd8;
  localparam logic [5:0] OP_SLTU  = 6'd9;
  localparam logic [5:0] OP_SLL   = 6'd10;
  localparam logic [5:0] OP_SRL   = 6'd11;
  localparam logic [5:0] OP_SRA   = 6'd12;
  localparam logic [5:0] OP_DIV   = 6'd13;
  localparam logic [5:0] OP_DIVU  = 6'd14;
  localparam logic [5:0] OP_REM   = 6'd15;
  localparam logic [5:0] OP_REMU  = 6'd16;
  localparam logic [5:0] OP_ADDW  = 6'd17;
  localparam logic [5:0] OP_MULW  = 6'd18;
  localparam logic [5:0] OP_SUBW  = 6'd19;
  localparam logic [5:0] OP_SLLW  = 6'd20;
  localparam logic [5:0] OP_SRLW  = 6'd21;
  localparam logic [5:0] OP_SRAW  = 6'd22;
  localparam logic [5:0] OP_DIVW  = 6'd23;
  localparam logic [5:0] OP_DIVUW = 6'd24;
  localparam logic [5:0] OP_REMW  = 6'd25;
  localparam logic [5:0] OP_REMUW = 6'd26;
  localparam logic [5:0] OP_JAL   = 6'd27;
  localparam logic [5:0] OP_JALR  = 6'd28;
  localparam logic [5:0] OP_BEQ   = 6'd29;
  localparam logic [5:0] OP_BNE   = 6'd30;
  localparam logic [5:0] OP_BLT   = 6'd31;
  localparam logic [5:0] OP_BGE   = 6'd32;
  localparam logic [5:0] OP_BLTU  = 6'd33;
  localparam logic [5:0] OP_BGEU  = 6'd34;
  localparam logic [5:0] OP_LD    = 6'd35;
  localparam logic [5:0] OP_LW    = 6'd36;
  localparam logic [5:0] OP_LH    = 6'd37;
  localparam logic [5:0] OP_LB    = 6'd38;
  localparam logic [5:0] OP_LWU   = 6'd39;
  localparam logic [5:0] OP_LHU   = 6'd40;
  localparam logic [5:0] OP_LBU   = 6'd41;
  localparam logic [5:0] OP_SD    = 6'd42;
  localparam logic [5:0] OP_SW    = 6'd43;
  localparam logic [5:0] OP_SH    = 6'd44;
  localparam logic [5:0] OP_SB    = 6'd45;

  // instruction classes
  localparam logic [3:0] CLS_ALU     = 4'd0;
  localparam logic [3:0] CLS_AUIPC   = 4'd1;
  localparam logic [3:0] CLS_LUI     = 4'd2;
  localparam logic [3:0] CLS_JAL     = 4'd3;
  localparam logic [3:0] CLS_JALR    = 4'd4;
  localparam logic [3:0] CLS_BRANCH  = 4'd5;
  localparam logic [3:0] CLS_LOAD    = 4'd6;
  localparam logic [3:0] CLS_STORE   = 4'd7;
  localparam logic [3:0] CLS_INVALID = 4'd8;

  // which iterative unit a word uses in the cell chain
  localparam logic [1:0] UNIT_NONE = 2'd0;
  localparam logic [1:0] UNIT_MUL  = 2'd1;
  localparam logic [1:0] UNIT_DIV  = 2'd2;

  localparam logic [63:0] LUI_MASK = 64'hffff_ffff_ffff_f000;

  typedef struct packed {
    logic [63:0] result;
    logic [63:0] next_pc;
    logic        taken;
    logic [63:0] mem_address;
    logic [3:0]  mem_bytes;
    logic        mem_signed;
    logic [3:0]  op_class;
    logic        fault;
    logic [1:0]  unit;
    logic        want_rem;
    logic        w_form;
    logic        neg_q;
    logic        neg_r;
    logic        div_zero;
  } meta_t;

  // acc: product / partial remainder; opd: multiplicand / divisor;
  // sh: multiplier bits / dividend shifting into quotient
  typedef struct packed {
    logic [63:0] acc;
    logic [63:0] opd;
    logic [63:0] sh;
  } arith_t;

  typedef struct packed {
    meta_t  m;
    arith_t a;
  } stage_t;

  function automatic logic [63:0] sext32(logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

  // one radix-2 step of shift-add multiply or restoring divide
  function automatic arith_t arith_step(arith_t s, logic [1:0] unit);
    arith_t      n;
    logic [64:0] t;
    logic [64:0] diff;
    n    = s;
    t    = {s.acc, s.sh[63]};
    diff = t - {1'b0, s.opd};
    case (unit)
      UNIT_DIV: begin
        if (t >= {1'b0, s.opd}) begin
          n.acc = diff[63:0];
          n.sh  = {s.sh[62:0], 1'b1};
        end else begin
          n.acc = t[63:0];
          n.sh  = {s.sh[62:0], 1'b0};
        end
      end
      UNIT_MUL: begin
        if (s.sh[0]) begin
          n.acc = s.acc + s.opd;
        end
        n.opd = {s.opd[62:0], 1'b0};
        n.sh  = {1'b0, s.sh[63:1]};
      end
      default: begin
        n = s;
      end
    endcase
    return n;
  endfunction

endpackage

// File: src/rv64ex_front.sv
// Decode and combinational ALU, branch, jump and address work.
// Sets up multiply/divide operands for the cell chain. Uses rv64ex_pkg.
module rv64ex_front import rv64ex_pkg::*; (
  input  logic [5:0]  opcode,
  input  logic [63:0] operand_a,
  input  logic [63:0] operand_b,
  input  logic [63:0] offset,
  input  logic [63:0] pc_now,
  input  logic [63:0] pc_sequential,
  output stage_t      st
);

  logic [5:0]  s6;
  logic [4:0]  s5;
  logic        lts;
  logic        ltu;
  logic [63:0] da;
  logic [63:0] db;
  logic        sgn;
  logic [63:0] sum_ab;
  logic [63:0] a_w;

  assign s6     = operand_b[5:0];
  assign s5     = operand_b[4:0];
  assign lts    = $signed(operand_a) < $signed(operand_b);
  assign ltu    = operand_a < operand_b;
  assign sum_ab = operand_a + operand_b;
  assign a_w    = sext32(operand_a);

  // divider operands as 64-bit values
  always_comb begin
    da  = operand_a;
    db  = operand_b;
    sgn = 1'b0;
    case (opcode)
      OP_DIV, OP_REM: begin
        sgn = 1'b1;
      end
      OP_DIVW, OP_REMW: begin
        da  = a_w;
        db  = sext32(operand_b);
        sgn = 1'b1;
      end
      OP_DIVUW, OP_REMUW: begin
        da = {32'd0, operand_a[31:0]};
        db = {32'd0, operand_b[31:0]};
      end
      default: begin
        sgn = 1'b0;
      end
    endcase
  end

  always_comb begin
    st             = '0;
    st.m.next_pc   = pc_sequential;
    case (opcode)
      OP_AUIPC: begin st.m.op_class = CLS_AUIPC; st.m.result = operand_a + pc_now; end
      OP_LUI:   begin st.m.op_class = CLS_LUI; st.m.result = operand_a & LUI_MASK; end
      OP_ADD:   st.m.result = sum_ab;
      OP_SUB:   st.m.result = operand_a - operand_b;
      OP_OR:    st.m.result = operand_a | operand_b;
      OP_XOR:   st.m.result = operand_a ^ operand_b;
      OP_AND:   st.m.result = operand_a & operand_b;
      OP_SLT:   st.m.result = {63'd0, lts};
      OP_SLTU:  st.m.result = {63'd0, ltu};
      OP_SLL:   st.m.result = operand_a << s6;
      OP_SRL:   st.m.result = operand_a >> s6;
      OP_SRA:   st.m.result = $unsigned($signed(operand_a) >>> s6);
      OP_ADDW:  st.m.result = sext32(sum_ab);
      OP_SUBW:  st.m.result = sext32(operand_a - operand_b);
      OP_SLLW:  st.m.result = sext32(operand_a << s5);
      OP_SRLW:  st.m.result = sext32({32'd0, operand_a[31:0]} >> s5);
      OP_SRAW:  st.m.result = sext32($unsigned($signed(a_w) >>> s5));
      OP_MUL, OP_MULW: begin
        st.m.unit   = UNIT_MUL;
        st.m.w_form = (opcode == OP_MULW);
        st.a.opd    = operand_a;
        st.a.sh     = operand_b;
      end
      OP_DIV, OP_DIVU, OP_REM, OP_REMU, OP_DIVW, OP_DIVUW, OP_REMW, OP_REMUW: begin
        st.m.unit     = UNIT_DIV;
        st.m.want_rem = (opcode == OP_REM) || (opcode == OP_REMU) ||
                        (opcode == OP_REMW) || (opcode == OP_REMUW);
        st.m.w_form   = (opcode == OP_DIVW) || (opcode == OP_DIVUW) ||
                        (opcode == OP_REMW) || (opcode == OP_REMUW);
        st.m.neg_q    = sgn && (da[63] != db[63]);
        st.m.neg_r    = sgn && da[63];
        st.m.div_zero = (db == 64'd0);
        // divide-by-zero answer, chosen at the end of the chain
        st.m.result   = st.m.want_rem ? da : '1;
        st.a.opd      = (sgn && db[63]) ? (64'd0 - db) : db;
        st.a.sh       = (sgn && da[63]) ? (64'd0 - da) : da;
      end
      OP_JAL: begin
        st.m.op_class = CLS_JAL;
        st.m.result   = pc_sequential;
        st.m.next_pc  = pc_now + operand_a;
      end
      OP_JALR: begin
        st.m.op_class = CLS_JALR;
        st.m.result   = pc_sequential;
        st.m.next_pc  = {sum_ab[63:1], 1'b0};
      end
      OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
        st.m.op_class = CLS_BRANCH;
        case (opcode)
          OP_BEQ:  st.m.taken = (operand_a == operand_b);
          OP_BNE:  st.m.taken = (operand_a != operand_b);
          OP_BLT:  st.m.taken = lts;
          OP_BGE:  st.m.taken = !lts;
          OP_BLTU: st.m.taken = ltu;
          default: st.m.taken = !ltu;
        endcase
        if (st.m.taken) begin
          st.m.next_pc = pc_now + offset;
        end
      end
      OP_LD, OP_LW, OP_LH, OP_LB, OP_LWU, OP_LHU, OP_LBU: begin
        st.m.op_class    = CLS_LOAD;
        st.m.mem_address = sum_ab;
        st.m.mem_signed  = (opcode == OP_LW) || (opcode == OP_LH) || (opcode == OP_LB);
        case (opcode)
          OP_LD:         st.m.mem_bytes = 4'd8;
          OP_LW, OP_LWU: st.m.mem_bytes = 4'd4;
          OP_LH, OP_LHU: st.m.mem_bytes = 4'd2;
          default:       st.m.mem_bytes = 4'd1;
        endcase
      end
      OP_SD, OP_SW, OP_SH, OP_SB: begin
        st.m.op_class    = CLS_STORE;
        st.m.mem_address = operand_a + offset;
        case (opcode)
          OP_SD:   st.m.mem_bytes = 4'd8;
          OP_SW:   st.m.mem_bytes = 4'd4;
          OP_SH:   st.m.mem_bytes = 4'd2;
          default: st.m.mem_bytes = 4'd1;
        endcase
      end
      default: begin
        st.m.op_class = CLS_INVALID;
        st.m.fault    = 1'b1;
      end
    endcase
  end

endmodule

// File: src/rv64ex_cell.sv
// One cell of the multiply/divide chain: two radix-2 steps and a stage register.
// Uses rv64ex_pkg.
module rv64ex_cell import rv64ex_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  stage_t up_data,
  output logic   dn_valid,
  input  logic   dn_ready,
  output stage_t dn_data
);

  logic   valid_r;
  logic   valid_nxt;
  stage_t data_r;
  stage_t data_nxt;
  arith_t stp [STEPS_PER_CELL+1];

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    stp[0] = up_data.a;
    for (int i = 0; i < STEPS_PER_CELL; i++) begin
      stp[i+1] = arith_step(stp[i], up_data.m.unit);
    end
    data_nxt   = up_data;
    data_nxt.a = stp[STEPS_PER_CELL];
    valid_nxt  = up_ready ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: src/rv64ex_back.sv
// Result finish: quotient/remainder sign fix, W-form extension, final select.
// Uses rv64ex_pkg.
module rv64ex_back import rv64ex_pkg::*; (
  input  stage_t      st,
  output logic [63:0] result
);

  logic [63:0] q;
  logic [63:0] r;
  logic [63:0] v;

  assign q = st.m.neg_q ? (64'd0 - st.a.sh) : st.a.sh;
  assign r = st.m.neg_r ? (64'd0 - st.a.acc) : st.a.acc;

  always_comb begin
    case (st.m.unit)
      UNIT_MUL: v = st.a.acc;
      UNIT_DIV: v = st.m.div_zero ? st.m.result : (st.m.want_rem ? r : q);
      default:  v = st.m.result;
    endcase
    result = st.m.w_form ? sext32(v) : v;
  end

endmodule

// File: src/rv64im_integer_execute_unit.sv
// Top level of the rv64im execute unit: front decode, cell chain, output register.
// Uses rv64ex_pkg, rv64ex_front, rv64ex_cell, rv64ex_back.
//
//  channel | ports        | tdata (low bit up)                        | tuser
//  --------+--------------+-------------------------------------------+-----------------
//  input   | in_t*        | operand_a, operand_b, offset, pc_now,     | opcode
//          |              | pc_sequential                             |
//  result  | out_t*       | result, next_pc, taken, mem_address,      | op_class, fault
//          |              | mem_bytes, mem_signed, 2 zero pad bits    |
//
// One word in and one word out per cycle while out_tready is held high. A word passes
// the front register, 32 chain cells (two multiply or divide bits each,
// 64 bits in all) and the output register. Every word walks the whole chain,
// so results leave in input order.
// Each stage holds its own valid and takes a word when empty or draining, so
// bubbles close up while the output is stalled. Reset clears valid bits only.
module rv64im_integer_execute_unit import rv64ex_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [319:0] in_tdata,   // operand_a, operand_b, offset, pc_now, pc_sequential
  input  logic [5:0]   in_tuser,   // opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [199:0] out_tdata,  // result, next_pc, taken, mem_address, mem_bytes,
                                   // mem_signed, pad
  output logic [4:0]   out_tuser   // op_class, fault
);

  stage_t      front_st;
  logic        front_v_r;
  stage_t      front_r;
  logic        front_rdy;

  logic        cv  [NCELLS+1];
  logic        crd [NCELLS+1];
  stage_t      cd  [NCELLS+1];

  logic [63:0] fin_result;
  logic        out_rdy;
  logic        out_v_r;
  meta_t       out_m_r;
  logic [63:0] out_res_r;

  // decode and combinational work
  rv64ex_front u_front (
    .opcode        (in_tuser),
    .operand_a     (in_tdata[63:0]),
    .operand_b     (in_tdata[127:64]),
    .offset        (in_tdata[191:128]),
    .pc_now        (in_tdata[255:192]),
    .pc_sequential (in_tdata[319:256]),
    .st            (front_st)
  );

  assign front_rdy = !front_v_r || crd[0];
  assign in_tready = front_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_v_r <= 1'b0;
    end else if (front_rdy) begin
      front_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (front_rdy && in_tvalid) begin
      front_r <= front_st;
    end
  end

  assign cv[0] = front_v_r;
  assign cd[0] = front_r;

  // multiply/divide chain
  for (genvar g = 0; g < NCELLS; g++) begin : g_cell
    rv64ex_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[g]),
      .up_ready (crd[g]),
      .up_data  (cd[g]),
      .dn_valid (cv[g+1]),
      .dn_ready (crd[g+1]),
      .dn_data  (cd[g+1])
    );
  end

  assign crd[NCELLS] = out_rdy;

  rv64ex_back u_back (
    .st     (cd[NCELLS]),
    .result (fin_result)
  );

  // output register; holds while the sink stalls
  assign out_rdy = !out_v_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_rdy) begin
      out_v_r <= cv[NCELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy && cv[NCELLS]) begin
      out_m_r   <= cd[NCELLS].m;
      out_res_r <= fin_result;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_m_r.mem_signed, out_m_r.mem_bytes, out_m_r.mem_address,
                       out_m_r.taken, out_m_r.next_pc, out_res_r};
  assign out_tuser  = {out_m_r.fault, out_m_r.op_class};

endmodule

// File: src/rv64ex_checker.sv
// Port-level checker for the rv64im execute unit, bound to the top level.
// Uses rv64ex_pkg and rv64im_integer_execute_unit_defines.svh.
`include "rv64im_integer_execute_unit_defines.svh"

module rv64ex_checker import rv64ex_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [199:0] out_tdata,
  input logic [4:0]   out_tuser
);

  // a stalled result word holds
  `RV64EX_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // fault flag goes exactly with the invalid class
  `RV64EX_ASSERT_NOW(a_fault_cls, out_tvalid, out_tuser[4] == (out_tuser[3:0] == CLS_INVALID))

  // only branches may report taken
  `RV64EX_ASSERT_NOW(a_taken_br, out_tvalid && out_tuser[3:0] != CLS_BRANCH, !out_tdata[128])

  // access width only on loads and stores
  `RV64EX_ASSERT_NOW(a_mem_cls, out_tvalid && out_tdata[196:193] != 4'd0,
                     out_tuser[3:0] == CLS_LOAD || out_tuser[3:0] == CLS_STORE)

endmodule

bind rv64im_integer_execute_unit rv64ex_checker u_rv64ex_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
